// ===== design/otm_pkg.sv =====
package otm_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int GAIN_W      = 8;
  localparam int PROD_W      = SAMPLE_BITS + GAIN_W;
  localparam int DIV_W       = 17;
  localparam int CMP_W       = (PROD_W > DIV_W) ? PROD_W : DIV_W;
  localparam int H_W         = 14;
  localparam int Q2_W        = 10;
  localparam int Q3_W        = 7;
  localparam int BCD_W       = 16;
  localparam int NUM_STAGES  = 5;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic [CMP_W-1:0] OVER_THR = CMP_W'(99990);
  // x/10 == (x * 52429) >> 19 holds exactly for x below 262144
  localparam logic [15:0]      RECIP10  = 16'd52429;
  localparam int               RECIP_SH = 19;

  localparam logic [2:0] REG_LIMIT_GAIN     = 3'd0;
  localparam logic [2:0] REG_POS_VOLT_GAIN  = 3'd1;
  localparam logic [2:0] REG_NEG_VOLT_GAIN  = 3'd2;
  localparam logic [2:0] REG_CURRENT_GAIN   = 3'd3;
  localparam logic [2:0] REG_REFRESH_PERIOD = 3'd4;

  localparam logic [7:0] RST_LIMIT_GAIN     = 8'd10;
  localparam logic [7:0] RST_VOLT_GAIN      = 8'd48;
  localparam logic [7:0] RST_CURRENT_GAIN   = 8'd10;
  localparam logic [7:0] RST_REFRESH_PERIOD = 8'd50;

  typedef struct packed {
    logic [GAIN_W-1:0] limit_gain;
    logic [GAIN_W-1:0] pos_volt_gain;
    logic [GAIN_W-1:0] neg_volt_gain;
    logic [GAIN_W-1:0] current_gain;
    logic [7:0]        refresh_period;
  } otm_cfg_t;

  typedef struct packed {
    logic relay_on;
    logic tripped;
    logic display_valid;
    logic refresh;
  } otm_ctrl_t;

  function automatic logic [DIV_W-1:0] div10(input logic [DIV_W-1:0] x);
    logic [DIV_W+15:0] m;
    m = (DIV_W+16)'(x) * (DIV_W+16)'(RECIP10);
    return DIV_W'(m >> RECIP_SH);
  endfunction

endpackage

// ===== design/otm_cfg.sv =====
module otm_cfg
  import otm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output otm_cfg_t          cfg_o
);

  otm_cfg_t   cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_LIMIT_GAIN:     cfg_d.limit_gain     = pwdata[7:0];
        REG_POS_VOLT_GAIN:  cfg_d.pos_volt_gain  = pwdata[7:0];
        REG_NEG_VOLT_GAIN:  cfg_d.neg_volt_gain  = pwdata[7:0];
        REG_CURRENT_GAIN:   cfg_d.current_gain   = pwdata[7:0];
        REG_REFRESH_PERIOD: cfg_d.refresh_period = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LIMIT_GAIN:     prdata = DATA_W'(cfg_q.limit_gain);
      REG_POS_VOLT_GAIN:  prdata = DATA_W'(cfg_q.pos_volt_gain);
      REG_NEG_VOLT_GAIN:  prdata = DATA_W'(cfg_q.neg_volt_gain);
      REG_CURRENT_GAIN:   prdata = DATA_W'(cfg_q.current_gain);
      REG_REFRESH_PERIOD: prdata = DATA_W'(cfg_q.refresh_period);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_gain     <= RST_LIMIT_GAIN;
      cfg_q.pos_volt_gain  <= RST_VOLT_GAIN;
      cfg_q.neg_volt_gain  <= RST_VOLT_GAIN;
      cfg_q.current_gain   <= RST_CURRENT_GAIN;
      cfg_q.refresh_period <= RST_REFRESH_PERIOD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== design/otm_lane.sv =====
module otm_lane
  import otm_pkg::*;
(
  input  logic                   clk_i,
  input  logic [NUM_STAGES-1:0]  en_i,
  input  logic [SAMPLE_BITS-1:0] raw_i,
  input  logic [GAIN_W-1:0]      gain_i,
  output logic [PROD_W-1:0]      prod_o,
  output logic [BCD_W-1:0]       bcd_o,
  output logic                   over_o
);

  logic [PROD_W-1:0] prod_q;
  logic [H_W-1:0]    h_q, h_d;
  logic              over2_q, over3_q, over4_q, over5_q, over_d;
  logic [Q2_W-1:0]   q2_q, q2_d;
  logic [3:0]        d0_3_q, d0_4_q, d0_d;
  logic [Q3_W-1:0]   q3_q, q3_d;
  logic [3:0]        d1_q, d1_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [DIV_W-1:0]  x, q_a, q_b, q_c;
  logic [H_W-1:0]    q2x;
  logic [Q2_W-1:0]   q3x;
  logic [Q3_W-1:0]   d3x;
  logic [3:0]        d2, d3;

  // stage 2: overload check and thousandths to hundredths
  always_comb begin
    over_d = CMP_W'(prod_q) > OVER_THR;
    x      = over_d ? '0 : DIV_W'(prod_q);
    q_a    = div10(x);
    h_d    = H_W'(q_a);
  end

  // stage 3: hundredths digit
  always_comb begin
    q_b  = div10(DIV_W'(h_q));
    q2_d = Q2_W'(q_b);
    q2x  = H_W'(q2_d);
    d0_d = 4'(h_q - ((q2x << 3) + (q2x << 1)));
  end

  // stage 4: tenths digit
  always_comb begin
    q_c  = div10(DIV_W'(q2_q));
    q3_d = Q3_W'(q_c);
    q3x  = Q2_W'(q3_d);
    d1_d = 4'(q2_q - ((q3x << 3) + (q3x << 1)));
  end

  // stage 5: units and tens
  always_comb begin
    d3    = 4'(div10(DIV_W'(q3_q)));
    d3x   = Q3_W'(d3);
    d2    = 4'(q3_q - ((d3x << 3) + (d3x << 1)));
    bcd_d = {d3, d2, d1_q, d0_4_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= PROD_W'(raw_i) * PROD_W'(gain_i);
    end
    if (en_i[1]) begin
      h_q     <= h_d;
      over2_q <= over_d;
    end
    if (en_i[2]) begin
      q2_q    <= q2_d;
      d0_3_q  <= d0_d;
      over3_q <= over2_q;
    end
    if (en_i[3]) begin
      q3_q    <= q3_d;
      d1_q    <= d1_d;
      d0_4_q  <= d0_3_q;
      over4_q <= over3_q;
    end
    if (en_i[4]) begin
      bcd_q   <= bcd_d;
      over5_q <= over4_q;
    end
  end

  assign prod_o = prod_q;
  assign bcd_o  = bcd_q;
  assign over_o = over5_q;

endmodule

// ===== design/otm_ctrl.sv =====
module otm_ctrl
  import otm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [NUM_STAGES-1:0] en_i,
  input  logic                  kind_i,
  input  logic [PROD_W-1:0]     lim_prod_i,
  input  logic [PROD_W-1:0]     cur_prod_i,
  input  logic [7:0]            refresh_period_i,
  output otm_ctrl_t             ctrl_o
);

  logic      kind_q;
  logic      latch_q, latch_d;
  logic [7:0] cnt_q, cnt_d, cnt_inc;
  logic      trip;
  otm_ctrl_t c_d, c2_q, c3_q, c4_q, c5_q;

  always_comb begin
    latch_d = latch_q;
    cnt_d   = cnt_q;
    cnt_inc = cnt_q + 8'd1;
    trip    = cur_prod_i > lim_prod_i;
    c_d     = '0;
    if (kind_q) begin
      latch_d    = 1'b0;
      c_d.relay_on = 1'b1;
    end else if (latch_q) begin
      c_d.tripped = 1'b1;
    end else begin
      cnt_d             = (cnt_inc >= refresh_period_i) ? 8'd0 : cnt_inc;
      latch_d           = trip;
      c_d.relay_on      = !trip;
      c_d.tripped       = trip;
      c_d.display_valid = 1'b1;
      c_d.refresh       = (cnt_q == 8'd0) || trip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= 1'b0;
      cnt_q   <= 8'd0;
    end else if (en_i[1]) begin
      latch_q <= latch_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) kind_q <= kind_i;
    if (en_i[1]) c2_q <= c_d;
    if (en_i[2]) c3_q <= c2_q;
    if (en_i[3]) c4_q <= c3_q;
    if (en_i[4]) c5_q <= c4_q;
  end

  assign ctrl_o = c5_q;

endmodule

// ===== design/overcurrent_trip_monitor.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    kind_i, four *_raw_i readings
// output    out        out_valid_o / out_stall_i  relay/trip/refresh flags, four BCD + over
// config    in         APB psel/penable/pwrite    five 8-bit registers at 4*i
//
// Five-stage pipeline, one transaction per cycle unless out_stall_i holds it; out_valid_o
// marks a result in stage 5. Trip latch and refresh counter update in stage 2, in order.
// Each stage holds while the next one is full and stalled, so bubbles fill under stall.
// Reset clears valid bits, trip latch and refresh counter and loads register defaults.
module overcurrent_trip_monitor
  import otm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   kind_i,
  input  logic [SAMPLE_BITS-1:0] limit_raw_i,
  input  logic [SAMPLE_BITS-1:0] pos_volt_raw_i,
  input  logic [SAMPLE_BITS-1:0] neg_volt_raw_i,
  input  logic [SAMPLE_BITS-1:0] current_raw_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   relay_on_o,
  output logic                   tripped_o,
  output logic                   display_valid_o,
  output logic                   refresh_o,
  output logic [BCD_W-1:0]       limit_bcd_o,
  output logic                   limit_over_o,
  output logic [BCD_W-1:0]       pos_volt_bcd_o,
  output logic                   pos_volt_over_o,
  output logic [BCD_W-1:0]       neg_volt_bcd_o,
  output logic                   neg_volt_over_o,
  output logic [BCD_W-1:0]       current_bcd_o,
  output logic                   current_over_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  otm_cfg_t              cfg;
  otm_ctrl_t             ctrl;
  logic [NUM_STAGES-1:0] v_q, v_d, rdy, en, v_prev;
  logic [PROD_W-1:0]     lim_prod, pv_prod, nv_prod, cur_prod;
  logic [BCD_W-1:0]      lim_bcd, pv_bcd, nv_bcd, cur_bcd;
  logic                  lim_over, pv_over, nv_over, cur_over;

  always_comb begin
    v_prev = {v_q[NUM_STAGES-2:0], in_valid_i};
    rdy[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    en  = rdy & v_prev;
    v_d = v_q;
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (rdy[k]) v_d[k] = v_prev[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  otm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  otm_lane u_lane_lim (
    .clk_i  (clk_i),
    .en_i   (en),
    .raw_i  (limit_raw_i),
    .gain_i (cfg.limit_gain),
    .prod_o (lim_prod),
    .bcd_o  (lim_bcd),
    .over_o (lim_over)
  );

  otm_lane u_lane_pv (
    .clk_i  (clk_i),
    .en_i   (en),
    .raw_i  (pos_volt_raw_i),
    .gain_i (cfg.pos_volt_gain),
    .prod_o (pv_prod),
    .bcd_o  (pv_bcd),
    .over_o (pv_over)
  );

  otm_lane u_lane_nv (
    .clk_i  (clk_i),
    .en_i   (en),
    .raw_i  (neg_volt_raw_i),
    .gain_i (cfg.neg_volt_gain),
    .prod_o (nv_prod),
    .bcd_o  (nv_bcd),
    .over_o (nv_over)
  );

  otm_lane u_lane_cur (
    .clk_i  (clk_i),
    .en_i   (en),
    .raw_i  (current_raw_i),
    .gain_i (cfg.current_gain),
    .prod_o (cur_prod),
    .bcd_o  (cur_bcd),
    .over_o (cur_over)
  );

  otm_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .kind_i           (kind_i),
    .lim_prod_i       (lim_prod),
    .cur_prod_i       (cur_prod),
    .refresh_period_i (cfg.refresh_period),
    .ctrl_o           (ctrl)
  );

  // readouts only carry data for displayed samples
  assign relay_on_o      = ctrl.relay_on;
  assign tripped_o       = ctrl.tripped;
  assign display_valid_o = ctrl.display_valid;
  assign refresh_o       = ctrl.refresh;
  assign limit_bcd_o     = lim_bcd & {BCD_W{ctrl.display_valid}};
  assign pos_volt_bcd_o  = pv_bcd & {BCD_W{ctrl.display_valid}};
  assign neg_volt_bcd_o  = nv_bcd & {BCD_W{ctrl.display_valid}};
  assign current_bcd_o   = cur_bcd & {BCD_W{ctrl.display_valid}};
  assign limit_over_o    = lim_over && ctrl.display_valid;
  assign pos_volt_over_o = pv_over && ctrl.display_valid;
  assign neg_volt_over_o = nv_over && ctrl.display_valid;
  assign current_over_o  = cur_over && ctrl.display_valid;

  // pos/neg products feed only the readout path
  logic unused_prod;
  assign unused_prod = ^{pv_prod, nv_prod};

endmodule

// ===== sim/tb_overcurrent_trip_monitor.sv =====
module tb_overcurrent_trip_monitor;
  import otm_pkg::*;

  typedef enum logic {
    SET_SAMPLES     = 1'b0,
    SET_RESET_PRESS = 1'b1
  } set_kind_e;

  typedef struct packed {
    set_kind_e              kind;
    logic [SAMPLE_BITS-1:0] limit_raw;
    logic [SAMPLE_BITS-1:0] pos_volt_raw;
    logic [SAMPLE_BITS-1:0] neg_volt_raw;
    logic [SAMPLE_BITS-1:0] current_raw;
  } adc_set_t;

  typedef struct packed {
    logic             relay_on;
    logic             tripped;
    logic             display_valid;
    logic             refresh;
    logic [BCD_W-1:0] limit_bcd;
    logic             limit_over;
    logic [BCD_W-1:0] pos_volt_bcd;
    logic             pos_volt_over;
    logic [BCD_W-1:0] neg_volt_bcd;
    logic             neg_volt_over;
    logic [BCD_W-1:0] current_bcd;
    logic             current_over;
  } panel_t;

  typedef struct packed {
    logic       is_write;
    logic [2:0] reg_idx;
    logic [7:0] reg_val;
    adc_set_t   item;
    logic       typed;
    panel_t     want;
  } plan_row_t;

  localparam logic [2:0]  REG_SPARE_LO = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;
  localparam int unsigned OVER_MILLI   = 99990;
  localparam int unsigned MAX_RAW      = (1 << SAMPLE_BITS) - 1;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          NUM_PHASES   = 8;
  localparam int          SETS_PER_PHASE = 188;

  localparam adc_set_t NO_SET = '0;
  localparam adc_set_t PRESS  = '{SET_RESET_PRESS, 10'd0, 10'd0, 10'd0, 10'd0};
  localparam panel_t   NO_PANEL      = '0;
  localparam panel_t   PRESS_PANEL   = '{1'b1, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0,
                                         16'h0, 1'b0, 16'h0, 1'b0};
  localparam panel_t   IGNORED_PANEL = '{1'b0, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0,
                                         16'h0, 1'b0, 16'h0, 1'b0};

  localparam int N_PLAN = 29;
  localparam plan_row_t PLAN [N_PLAN] = '{
    '{1'b0, '0, '0, PRESS, 1'b1, PRESS_PANEL},
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b1,
      '{1'b1, 1'b0, 1'b1, 1'b1, 16'h0, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0}},
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd1023, 10'd1023, 10'd1023, 10'd0}, 1'b1,
      '{1'b1, 1'b0, 1'b1, 1'b0, 16'h1023, 1'b0, 16'h4910, 1'b0, 16'h4910, 1'b0,
        16'h0, 1'b0}},
    // smallest current over a zero limit trips
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd0, 10'd0, 10'd0, 10'd1}, 1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b1, 16'h0, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0, 16'h0001, 1'b0}},
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd1023, 10'd1023, 10'd1023, 10'd0}, 1'b1,
      IGNORED_PANEL},
    '{1'b0, '0, '0, PRESS, 1'b1, PRESS_PANEL},
    '{1'b0, '0, '0, PRESS, 1'b1, PRESS_PANEL},
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd500, 10'h2AA, 10'h155, 10'd500}, 1'b0, NO_PANEL},
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd1023, 10'h155, 10'h2AA, 10'd1022}, 1'b0, NO_PANEL},
    '{1'b1, REG_LIMIT_GAIN,     8'd110, NO_SET, 1'b0, NO_PANEL},
    '{1'b1, REG_POS_VOLT_GAIN,  8'd110, NO_SET, 1'b0, NO_PANEL},
    '{1'b1, REG_NEG_VOLT_GAIN,  8'd255, NO_SET, 1'b0, NO_PANEL},
    '{1'b1, REG_CURRENT_GAIN,   8'd110, NO_SET, 1'b0, NO_PANEL},
    '{1'b1, REG_REFRESH_PERIOD, 8'd0,   NO_SET, 1'b0, NO_PANEL},
    // 99.99 exactly vs one count above
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd909, 10'd910, 10'd1023, 10'd909}, 1'b0, NO_PANEL},
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd908, 10'd0, 10'd392, 10'd909}, 1'b0, NO_PANEL},
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b1, IGNORED_PANEL},
    '{1'b0, '0, '0, PRESS, 1'b1, PRESS_PANEL},
    '{1'b1, REG_SPARE_LO,       8'hFF,  NO_SET, 1'b0, NO_PANEL},
    '{1'b1, REG_SPARE_HI,       8'hA5,  NO_SET, 1'b0, NO_PANEL},
    '{1'b1, REG_CURRENT_GAIN,   8'd0,   NO_SET, 1'b0, NO_PANEL},
    '{1'b1, REG_REFRESH_PERIOD, 8'd255, NO_SET, 1'b0, NO_PANEL},
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd0, 10'd1023, 10'd0, 10'd1023}, 1'b0, NO_PANEL},
    '{1'b1, REG_CURRENT_GAIN,   8'd255, NO_SET, 1'b0, NO_PANEL},
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd1023, 10'd1, 10'd1, 10'd393}, 1'b0, NO_PANEL},
    '{1'b0, '0, '0, PRESS, 1'b1, PRESS_PANEL},
    '{1'b1, REG_REFRESH_PERIOD, 8'd1,   NO_SET, 1'b0, NO_PANEL},
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd1, 10'd2, 10'd3, 10'd0}, 1'b0, NO_PANEL},
    '{1'b0, '0, '0, '{SET_SAMPLES, 10'd1, 10'd2, 10'd3, 10'd0}, 1'b0, NO_PANEL}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   kind_i;
  logic [SAMPLE_BITS-1:0] limit_raw_i;
  logic [SAMPLE_BITS-1:0] pos_volt_raw_i;
  logic [SAMPLE_BITS-1:0] neg_volt_raw_i;
  logic [SAMPLE_BITS-1:0] current_raw_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   relay_on_o;
  logic                   tripped_o;
  logic                   display_valid_o;
  logic                   refresh_o;
  logic [BCD_W-1:0]       limit_bcd_o;
  logic                   limit_over_o;
  logic [BCD_W-1:0]       pos_volt_bcd_o;
  logic                   pos_volt_over_o;
  logic [BCD_W-1:0]       neg_volt_bcd_o;
  logic                   neg_volt_over_o;
  logic [BCD_W-1:0]       current_bcd_o;
  logic                   current_over_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]      pwdata;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  otm_cfg_t   cfg;
  logic       latch_q;
  logic [7:0] refresh_cnt;
  panel_t     panel_q[$];
  int         mismatches = 0;
  int         quiet      = 0;
  int         send_pct   = 0;
  int         stall_pct  = 0;

  overcurrent_trip_monitor u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got_v, want_v);
    if (got_v !== want_v) report_mismatch($sformatf("%s got %0h want %0h", name, got_v, want_v));
  endtask

  function automatic void to_readout(input int unsigned milli, output logic [BCD_W-1:0] bcd,
                                     output logic over);
    int unsigned h;
    if (milli > OVER_MILLI) begin
      bcd  = '0;
      over = 1'b1;
    end else begin
      h    = milli / 10;
      bcd  = {4'(h / 1000 % 10), 4'(h / 100 % 10), 4'(h / 10 % 10), 4'(h % 10)};
      over = 1'b0;
    end
  endfunction

  // advances latch and refresh counter; one panel per transaction
  function automatic panel_t next_panel(input adc_set_t s);
    panel_t      p;
    int unsigned lim, pv, nv, cur;
    p = '0;
    if (s.kind == SET_RESET_PRESS) begin
      latch_q    = 1'b0;
      p.relay_on = 1'b1;
      return p;
    end
    if (latch_q) begin
      p.tripped = 1'b1;
      return p;
    end
    lim = s.limit_raw * cfg.limit_gain;
    pv  = s.pos_volt_raw * cfg.pos_volt_gain;
    nv  = s.neg_volt_raw * cfg.neg_volt_gain;
    cur = s.current_raw * cfg.current_gain;
    p.refresh   = (refresh_cnt == 8'd0);
    refresh_cnt = refresh_cnt + 8'd1;
    if (refresh_cnt >= cfg.refresh_period) refresh_cnt = 8'd0;
    if (cur > lim) begin
      latch_q   = 1'b1;
      p.refresh = 1'b1;
    end
    p.relay_on      = ~latch_q;
    p.tripped       = latch_q;
    p.display_valid = 1'b1;
    to_readout(lim, p.limit_bcd, p.limit_over);
    to_readout(pv, p.pos_volt_bcd, p.pos_volt_over);
    to_readout(nv, p.neg_volt_bcd, p.neg_volt_over);
    to_readout(cur, p.current_bcd, p.current_over);
    return p;
  endfunction

  function automatic logic [DATA_W-1:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_LIMIT_GAIN:     return DATA_W'(cfg.limit_gain);
      REG_POS_VOLT_GAIN:  return DATA_W'(cfg.pos_volt_gain);
      REG_NEG_VOLT_GAIN:  return DATA_W'(cfg.neg_volt_gain);
      REG_CURRENT_GAIN:   return DATA_W'(cfg.current_gain);
      REG_REFRESH_PERIOD: return DATA_W'(cfg.refresh_period);
      default:            return '0;
    endcase
  endfunction

  // mostly sets that keep the relay closed, some that trip just above the limit
  function automatic adc_set_t roll_set();
    adc_set_t    s;
    int unsigned lim_milli, room, pick;
    s.kind         = SET_SAMPLES;
    s.limit_raw    = SAMPLE_BITS'($urandom());
    s.pos_volt_raw = SAMPLE_BITS'($urandom());
    s.neg_volt_raw = SAMPLE_BITS'($urandom());
    s.current_raw  = SAMPLE_BITS'($urandom());
    if (latch_q) begin
      if ($urandom_range(0, 99) < 45) s.kind = SET_RESET_PRESS;
      return s;
    end
    if ($urandom_range(0, 99) < 4) begin
      s.kind = SET_RESET_PRESS;
      return s;
    end
    case ($urandom_range(0, 11))
      0: s.limit_raw = '1;
      1: s.limit_raw = '0;
      2: s.pos_volt_raw = '1;
      3: s.neg_volt_raw = '1;
      4: begin
        s.pos_volt_raw = '0;
        s.neg_volt_raw = '0;
      end
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (cfg.current_gain != 0 && pick < 75) begin
      lim_milli = s.limit_raw * cfg.limit_gain;
      room      = lim_milli / cfg.current_gain;
      if (room > MAX_RAW) room = MAX_RAW;
      if (pick < 60) s.current_raw = SAMPLE_BITS'($urandom_range(0, room));
      else if (pick < 68) s.current_raw = SAMPLE_BITS'(room);
      else if (room < MAX_RAW) s.current_raw = SAMPLE_BITS'(room + 1);
    end
    return s;
  endfunction

  task automatic offer_set(input adc_set_t s, input logic typed, input panel_t want);
    panel_t got;
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= s.kind;
    limit_raw_i    <= s.limit_raw;
    pos_volt_raw_i <= s.pos_volt_raw;
    neg_volt_raw_i <= s.neg_volt_raw;
    current_raw_i  <= s.current_raw;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    got = next_panel(s);
    panel_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (panel_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= {24'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    case (idx)
      REG_LIMIT_GAIN:     cfg.limit_gain     = val;
      REG_POS_VOLT_GAIN:  cfg.pos_volt_gain  = val;
      REG_NEG_VOLT_GAIN:  cfg.neg_volt_gain  = val;
      REG_CURRENT_GAIN:   cfg.current_gain   = val;
      REG_REFRESH_PERIOD: cfg.refresh_period = val;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_regs();
    logic [DATA_W-1:0] seen;
    for (int r = REG_LIMIT_GAIN; r <= REG_REFRESH_PERIOD; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'(r * 4);
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (pready !== 1'b1) @(posedge clk_i);
      seen = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
      check_field($sformatf("register %0d readback", r), seen, reg_value(3'(r)));
    end
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk_i) begin : watch_panel
    panel_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (panel_q.size() == 0) begin
        report_mismatch("display result with no transaction pending");
      end else begin
        want = panel_q.pop_front();
        check_field("relay_on", relay_on_o, want.relay_on);
        check_field("tripped", tripped_o, want.tripped);
        check_field("display_valid", display_valid_o, want.display_valid);
        check_field("refresh", refresh_o, want.refresh);
        check_field("limit_bcd", limit_bcd_o, want.limit_bcd);
        check_field("limit_over", limit_over_o, want.limit_over);
        check_field("pos_volt_bcd", pos_volt_bcd_o, want.pos_volt_bcd);
        check_field("pos_volt_over", pos_volt_over_o, want.pos_volt_over);
        check_field("neg_volt_bcd", neg_volt_bcd_o, want.neg_volt_bcd);
        check_field("neg_volt_over", neg_volt_over_o, want.neg_volt_over);
        check_field("current_bcd", current_bcd_o, want.current_bcd);
        check_field("current_over", current_over_o, want.current_over);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [7:0] vals [5];
    adc_set_t   s;
    int         counted;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    kind_i         <= 1'b0;
    limit_raw_i    <= '0;
    pos_volt_raw_i <= '0;
    neg_volt_raw_i <= '0;
    current_raw_i  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    cfg         = '{RST_LIMIT_GAIN, RST_VOLT_GAIN, RST_VOLT_GAIN, RST_CURRENT_GAIN,
                    RST_REFRESH_PERIOD};
    latch_q     = 1'b0;
    refresh_cnt = 8'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    for (int i = 0; i < N_PLAN; i++) begin
      if (PLAN[i].is_write) begin
        drain();
        reg_write(PLAN[i].reg_idx, PLAN[i].reg_val);
      end else begin
        offer_set(PLAN[i].item, PLAN[i].typed, PLAN[i].want);
      end
    end
    drain();
    check_regs();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 62; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 62; end
        default: begin send_pct = 35; stall_pct = 35; end
      endcase
      case (phase)
        0: vals = '{RST_LIMIT_GAIN, RST_VOLT_GAIN, RST_VOLT_GAIN, RST_CURRENT_GAIN,
                    RST_REFRESH_PERIOD};
        1: vals = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        2: vals = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
        default: begin
          foreach (vals[k]) vals[k] = 8'($urandom());
          vals[REG_REFRESH_PERIOD] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8))
                                                                 : 8'($urandom_range(1, 255));
        end
      endcase
      drain();
      for (int r = REG_LIMIT_GAIN; r <= REG_REFRESH_PERIOD; r++) reg_write(3'(r), vals[r]);
      check_regs();
      counted = 0;
      while (counted < SETS_PER_PHASE) begin
        s = roll_set();
        counted++;
        offer_set(s, 1'b0, NO_PANEL);
      end
    end

    drain();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/otm_pkg.sv
design/otm_cfg.sv
design/otm_lane.sv
design/otm_ctrl.sv
design/overcurrent_trip_monitor.sv
sim/tb_overcurrent_trip_monitor.sv
